>>> rtl/lfqr_pkg.sv
// Package for the LRC frame query responder: status codes, frame constants,
// register indexes, the job record passed from the receiver to the transmitter and answer frame helpers.
// Depends on nothing.
package lfqr_pkg;

   localparam logic [7:0] START_BYTE  = 8'h3A;
   localparam logic [7:0] CR_BYTE     = 8'h0D;
   localparam logic [7:0] LF_BYTE     = 8'h0A;
   localparam logic [7:0] CMD_QUERY   = 8'h01;
   localparam logic [7:0] CMD_ANSWER  = 8'h02;
   localparam logic [7:0] CMD_HISTORY = 8'h03;
   localparam logic [15:0] QUERY_LEN   = 16'd0;
   localparam logic [15:0] HISTORY_LEN = 16'd28;
   localparam logic [7:0] ANSWER_LEN_HI = 8'h00;
   localparam logic [7:0] ANSWER_LEN_LO = 8'h02;
   localparam logic [7:0] ZERO_BYTE   = 8'h00;

   localparam int MIN_FRAME  = 9;
   localparam int FLD_DEST   = 1;
   localparam int FLD_CMD    = 3;
   localparam int FLD_LEN_HI = 4;
   localparam int FLD_LEN_LO = 5;

   localparam int ANSWER_BYTES = 11;
   localparam int IDX_W        = $clog2(ANSWER_BYTES);

   localparam logic CSR_OWN_ADDRESS    = 1'b0;
   localparam logic CSR_MASTER_ADDRESS = 1'b1;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_HEADER      = 3'd1,
      ST_LRC         = 3'd2,
      ST_ADDR        = 3'd3,
      ST_UNSUPPORTED = 3'd4,
      ST_HISTORY     = 3'd5
   } status_type;

   typedef struct packed {
      logic        fire;
      status_type  status;
      logic [15:0] people;
   } lfqr_job_type;

   function automatic logic [7:0] answer_lrc(input logic [7:0] own_addr,
                                             input logic [7:0] host_addr,
                                             input logic [15:0] people);
      logic [7:0] sum;
      sum = own_addr + host_addr + CMD_ANSWER + ANSWER_LEN_HI + ANSWER_LEN_LO
            + people[15:8] + people[7:0];
      return 8'h00 - sum;
   endfunction

   function automatic logic [7:0] answer_byte(input logic [IDX_W-1:0] idx,
                                              input logic [7:0] own_addr,
                                              input logic [7:0] host_addr,
                                              input logic [15:0] people,
                                              input logic [7:0] lrc);
      logic [7:0] b;
      case (idx)
         IDX_W'(0): b = START_BYTE;
         IDX_W'(1): b = own_addr;
         IDX_W'(2): b = host_addr;
         IDX_W'(3): b = CMD_ANSWER;
         IDX_W'(4): b = ANSWER_LEN_HI;
         IDX_W'(5): b = ANSWER_LEN_LO;
         IDX_W'(6): b = people[15:8];
         IDX_W'(7): b = people[7:0];
         IDX_W'(8): b = lrc;
         IDX_W'(9): b = CR_BYTE;
         IDX_W'(10): b = LF_BYTE;
         default: b = ZERO_BYTE;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/lrc_frame_query_responder.sv
// Top level of the LRC frame query responder: configuration registers,
// frame receiver and response transmitter.
// Depends on lfqr_pkg, lfqr_frame_rx and lfqr_resp_tx.
//
// Each request is one received byte or one people count update; a byte that
// closes a chunk is judged in the same cycle it is taken, and its result
// enters the output register on the next edge. A failed check or a history
// query gives one status result, so such chunk ends can follow each other in
// consecutive cycles while the output is not stalled. An accepted query plays
// out an eleven-byte answer from the transmit sequencer, and the request side
// is stalled while that answer plays out, and for as long as the output
// register is full and stalled. Configuration writes are taken in any cycle.
module lrc_frame_query_responder
   import lfqr_pkg::*;
#(
   parameter int MAX_CHUNK = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_chunk_end,
   input  logic [15:0] req_people_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic [2:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0]   own_addr_ff, own_addr_in;
   logic [7:0]   host_addr_ff, host_addr_in;
   logic         req_accept;
   logic         tx_busy;
   lfqr_job_type job;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = tx_busy;

   always_comb begin
      own_addr_in  = own_addr_ff;
      host_addr_in = host_addr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OWN_ADDRESS: own_addr_in = csr_wdata;
            CSR_MASTER_ADDRESS: host_addr_in = csr_wdata;
            default: own_addr_in = own_addr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff  <= 8'h01;
         host_addr_ff <= 8'h00;
      end else begin
         own_addr_ff  <= own_addr_in;
         host_addr_ff <= host_addr_in;
      end
   end

   lfqr_frame_rx #(
      .MAX_CHUNK(MAX_CHUNK)
   ) u_rx (
      .clock        (clock),
      .reset        (reset),
      .item_accept  (req_accept),
      .action       (req_action),
      .rx_byte      (req_rx_byte),
      .chunk_end    (req_chunk_end),
      .people_count (req_people_count),
      .own_address  (own_addr_ff),
      .job          (job)
   );

   lfqr_resp_tx u_tx (
      .clock          (clock),
      .reset          (reset),
      .job            (job),
      .own_address    (own_addr_ff),
      .master_address (host_addr_ff),
      .rsp_stall      (rsp_stall),
      .busy           (tx_busy),
      .rsp_valid      (rsp_valid),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_tx_last    (rsp_tx_last),
      .rsp_status     (rsp_status)
   );

`ifndef ASSERT_OFF
   a_status_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_tx_last && rsp_tx_byte == ZERO_BYTE)
      else $error("status result is not a single last result with a zero byte");

   a_answer_holds_input : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK && !rsp_tx_last |-> req_stall)
      else $error("request taken while an answer frame is still playing out");

   a_answer_no_gap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_status == ST_OK && !rsp_tx_last |=> rsp_valid)
      else $error("answer frame broken by an idle cycle");

   a_chunk_end_result : assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_action && req_chunk_end |=> rsp_valid)
      else $error("chunk end produced no result");
`endif

endmodule

>>> rtl/lfqr_frame_rx.sv
// Frame receiver: tracks byte position, running sum, tail bytes and header fields
// over a chunk, holds the people count and judges the chunk at its end.
// Depends on lfqr_pkg.
module lfqr_frame_rx
   import lfqr_pkg::*;
#(
   parameter int MAX_CHUNK = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_accept,
   input  logic         action,
   input  logic [7:0]   rx_byte,
   input  logic         chunk_end,
   input  logic [15:0]  people_count,
   input  logic [7:0]   own_address,
   output lfqr_job_type job
);

   localparam int POS_W = $clog2(MAX_CHUNK + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHUNK);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [23:0]      tail_ff, tail_in;
   logic             start_ok_ff, start_ok_in;
   logic [7:0]       dest_ff, dest_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [15:0]      len_ff, len_in;
   logic [15:0]      people_ff, people_in;
   logic             overlong_ff, overlong_in;

   always_comb begin
      logic [7:0] body;
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      tail_in     = tail_ff;
      start_ok_in = start_ok_ff;
      dest_in     = dest_ff;
      cmd_in      = cmd_ff;
      len_in      = len_ff;
      people_in   = people_ff;
      overlong_in = overlong_ff;
      job.fire    = 1'b0;
      job.status  = ST_OK;
      job.people  = people_ff;
      body        = 8'h00;

      if (item_accept && action) begin
         people_in = people_count;
      end

      if (item_accept && !action) begin
         if (pos_ff == POS_MAX) begin
            overlong_in = 1'b1;
         end else begin
            if (pos_ff == POS_W'(0)) start_ok_in = (rx_byte == START_BYTE);
            if (pos_ff == POS_W'(FLD_DEST)) dest_in = rx_byte;
            if (pos_ff == POS_W'(FLD_CMD)) cmd_in = rx_byte;
            if (pos_ff == POS_W'(FLD_LEN_HI)) len_in = {rx_byte, len_ff[7:0]};
            if (pos_ff == POS_W'(FLD_LEN_LO)) len_in = {len_ff[15:8], rx_byte};
            if (pos_ff != POS_W'(0)) sum_in = sum_ff + rx_byte;
            tail_in = {tail_ff[15:0], rx_byte};
            pos_in  = pos_ff + 1'b1;
         end

         if (chunk_end) begin
            body = sum_in - tail_in[23:16] - tail_in[15:8] - tail_in[7:0];
            job.fire = 1'b1;
            if (overlong_in || !start_ok_in || pos_in < POS_W'(MIN_FRAME)) begin
               job.status = ST_HEADER;
            end else if ((8'h00 - body) != tail_in[23:16]) begin
               job.status = ST_LRC;
            end else if (dest_in != own_address) begin
               job.status = ST_ADDR;
            end else if (cmd_in == CMD_QUERY && len_in == QUERY_LEN) begin
               job.status = ST_OK;
            end else if (cmd_in == CMD_HISTORY && len_in == HISTORY_LEN) begin
               job.status = ST_HISTORY;
            end else begin
               job.status = ST_UNSUPPORTED;
            end
            pos_in      = '0;
            sum_in      = '0;
            tail_in     = '0;
            start_ok_in = 1'b0;
            dest_in     = '0;
            cmd_in      = '0;
            len_in      = '0;
            overlong_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         sum_ff      <= '0;
         tail_ff     <= '0;
         start_ok_ff <= 1'b0;
         dest_ff     <= '0;
         cmd_ff      <= '0;
         len_ff      <= '0;
         people_ff   <= '0;
         overlong_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         tail_ff     <= tail_in;
         start_ok_ff <= start_ok_in;
         dest_ff     <= dest_in;
         cmd_ff      <= cmd_in;
         len_ff      <= len_in;
         people_ff   <= people_in;
         overlong_ff <= overlong_in;
      end
   end

endmodule

>>> rtl/lfqr_resp_tx.sv
// Response transmitter: result register plus the sequencer that plays out
// the eleven-byte answer frame or a single status result.
// Depends on lfqr_pkg.
module lfqr_resp_tx
   import lfqr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  lfqr_job_type job,
   input  logic [7:0]   own_address,
   input  logic [7:0]   master_address,
   input  logic         rsp_stall,
   output logic         busy,
   output logic         rsp_valid,
   output logic [7:0]   rsp_tx_byte,
   output logic         rsp_tx_last,
   output logic [2:0]   rsp_status
);

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ANSWER_BYTES - 1);

   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;
   status_type       out_status_ff, out_status_in;
   logic             seq_active_ff, seq_active_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]      people_ff, people_in;
   logic [7:0]       lrc_ff, lrc_in;
   logic             load_ok;

   assign load_ok = !out_valid_ff || !rsp_stall;
   assign busy    = seq_active_ff || !load_ok;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      seq_active_in = seq_active_ff;
      idx_in        = idx_ff;
      people_in     = people_ff;
      lrc_in        = lrc_ff;

      if (seq_active_ff) begin
         if (load_ok) begin
            out_valid_in  = 1'b1;
            out_byte_in   = answer_byte(idx_ff, own_address, master_address,
                                        people_ff, lrc_ff);
            out_last_in   = (idx_ff == IDX_LAST);
            out_status_in = ST_OK;
            idx_in        = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) seq_active_in = 1'b0;
         end
      end else if (job.fire) begin
         out_valid_in  = 1'b1;
         out_status_in = job.status;
         if (job.status == ST_OK) begin
            out_byte_in   = START_BYTE;
            out_last_in   = 1'b0;
            seq_active_in = 1'b1;
            idx_in        = IDX_W'(1);
            people_in     = job.people;
            lrc_in        = answer_lrc(own_address, master_address, job.people);
         end else begin
            out_byte_in = ZERO_BYTE;
            out_last_in = 1'b1;
         end
      end else if (load_ok) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         seq_active_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         out_valid_ff  <= out_valid_in;
         seq_active_ff <= seq_active_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
      people_ff     <= people_in;
      lrc_ff        <= lrc_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_tx_byte = out_byte_ff;
   assign rsp_tx_last = out_last_ff;
   assign rsp_status  = out_status_ff;

endmodule
